>>> rtl/key_escape_decoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key escape decoder
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEY_ESCAPE_DECODER_MACROS_SVH
`define KEY_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication.
`define KED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ked_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ked_pkg
// Shared types and character constants of the key escape decoder.
// ----------------------------------------------------------------------------
package ked_pkg;

  localparam int unsigned CodeW = 9;
  localparam int unsigned UsedW = 3;

  // Character codes
  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDash      = 8'h2D;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChSeven     = 8'h37;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] ChQmark     = 8'h3F;
  localparam logic [7:0] ChAt        = 8'h40;
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperF    = 8'h46;
  localparam logic [7:0] ChUpperM    = 8'h4D;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerX    = 8'h78;
  localparam logic [7:0] ChLowerZ    = 8'h7A;

  // Escape results
  localparam logic [7:0] CodeBs = 8'h08;
  localparam logic [7:0] CodeFf = 8'h0C;
  localparam logic [7:0] CodeLf = 8'h0A;

  localparam logic [7:0] MetaBit = 8'h80;
  localparam logic [6:0] DelCode = 7'h7F;

  // Consumed byte counts
  localparam logic [UsedW-1:0] UsedNone  = 3'd0;
  localparam logic [UsedW-1:0] UsedOne   = 3'd1;
  localparam logic [UsedW-1:0] UsedTwo   = 3'd2;
  localparam logic [UsedW-1:0] UsedThree = 3'd3;
  localparam logic [UsedW-1:0] UsedFour  = 3'd4;

  // Per-byte classification
  typedef struct packed {
    logic [7:0] ch;
    logic       is_bslash;
    logic       is_caret;
    logic       is_m;
    logic       is_dash;
    logic       is_oct;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_qmark;
    logic       is_upper_ctl;  // '@' .. '_'
    logic       is_lower_ctl;  // 'a' .. 'z'
    logic       is_blank;      // NUL or white space
  } ked_class_t;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic             bad;
    logic [UsedW-1:0] used;
  } ked_res_t;

endpackage
`default_nettype wire

>>> rtl/ked_byte_class.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ked_byte_class
// Classifies one text byte: escape leaders, digits, caret operand ranges.
// ----------------------------------------------------------------------------
module ked_byte_class import ked_pkg::*; (
  input  wire logic [7:0] byte_i,
  output ked_class_t      class_o
);

  logic is_digit;
  logic is_lhex;
  logic is_uhex;

  always_comb begin
    is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
    is_lhex  = (byte_i >= ChLowerA) && (byte_i <= ChLowerF);
    is_uhex  = (byte_i >= ChUpperA) && (byte_i <= ChUpperF);

    class_o.ch           = byte_i;
    class_o.is_bslash    = (byte_i == ChBackslash);
    class_o.is_caret     = (byte_i == ChCaret);
    class_o.is_m         = (byte_i == ChUpperM);
    class_o.is_dash      = (byte_i == ChDash);
    class_o.is_oct       = (byte_i >= ChZero) && (byte_i <= ChSeven);
    class_o.is_hex       = is_digit || is_lhex || is_uhex;
    // letters: low nibble 1..6 plus 9 gives 10..15
    class_o.hex_val      = is_digit ? byte_i[3:0] : byte_i[3:0] + 4'd9;
    class_o.is_qmark     = (byte_i == ChQmark);
    class_o.is_upper_ctl = (byte_i >= ChAt) && (byte_i <= ChUnder);
    class_o.is_lower_ctl = (byte_i >= ChLowerA) && (byte_i <= ChLowerZ);
    class_o.is_blank     = (byte_i == ChNul) || (byte_i == ChSpace) ||
                           ((byte_i >= ChTab) && (byte_i <= ChCr));
  end

endmodule
`default_nettype wire

>>> rtl/key_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_escape_decoder
// Decodes one key notation at the start of a four-byte text window.
// ----------------------------------------------------------------------------
// Each request carries a four-byte window (bytes past the end of the text
// are NUL) and yields exactly one result: the character code, a bad-form
// flag and the number of bytes the notation used. A leading backslash
// starts a C escape (\\ \b \f \n \r \t, \x with one or two hex digits, one
// to three octal digits, bare \x giving 'x'; else a lone backslash, one byte).
// Otherwise an optional "M-" prefix sets bit 7, followed by caret control
// notation (^? ^@.. ^_ ^a.. ^z, caret before NUL or blank gives '^') or a
// plain byte. A caret before any other byte reports bad_form with code 0
// and consumed 0. Throughput is one request per clock while the output is
// not stalled; the result passes through three register stages: byte
// classification, escape/caret candidate decode, and final selection in
// the output register. Backpressure ripples stage by stage, so each stage
// refills as soon as the one ahead moves and no bubbles are added under
// stalls.
// ----------------------------------------------------------------------------
`include "key_escape_decoder_macros.svh"

module key_escape_decoder import ked_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: char0[7:0], char1[15:8], char2[23:16], char3[31:24]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: code[8:0], bad_form[9], consumed[12:10], zero pad[15:13]
  output logic [15:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  // --------------------------------------------------------------------------
  // Stage control: valid per stage, ready ripples back from the output
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: classify each byte of the window
  // --------------------------------------------------------------------------
  ked_class_t cls_d [4];
  ked_class_t cls_q [4];

  for (genvar i = 0; i < 4; i++) begin : g_class
    ked_byte_class u_class (
      .byte_i  (s_axis_tdata[8*i +: 8]),
      .class_o (cls_d[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid) begin
      cls_q <= cls_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: decode escape and text forms side by side
  // --------------------------------------------------------------------------
  ked_res_t   esc_d, esc_q;
  ked_res_t   txt_d, txt_q;
  logic       is_esc_q;
  logic       meta;
  ked_class_t lead;
  ked_class_t nxt;
  logic [7:0] e;

  always_comb begin
    e = cls_q[1].ch;

    // backslash escapes
    esc_d.bad  = 1'b0;
    esc_d.used = UsedTwo;
    esc_d.code = {1'b0, ChBackslash};
    case (1'b1)
      cls_q[1].is_bslash: esc_d.code = {1'b0, ChBackslash};
      (e == ChLowerB):    esc_d.code = {1'b0, CodeBs};
      (e == ChLowerF):    esc_d.code = {1'b0, CodeFf};
      (e == ChLowerN):    esc_d.code = {1'b0, CodeLf};
      (e == ChLowerR):    esc_d.code = {1'b0, ChCr};
      (e == ChLowerT):    esc_d.code = {1'b0, ChTab};
      (e == ChLowerX): begin
        if (cls_q[2].is_hex && cls_q[3].is_hex) begin
          esc_d.code = {1'b0, cls_q[2].hex_val, cls_q[3].hex_val};
          esc_d.used = UsedFour;
        end else if (cls_q[2].is_hex) begin
          esc_d.code = {5'b0, cls_q[2].hex_val};
          esc_d.used = UsedThree;
        end else begin
          esc_d.code = {1'b0, ChLowerX};
        end
      end
      cls_q[1].is_oct: begin
        if (cls_q[2].is_oct && cls_q[3].is_oct) begin
          esc_d.code = {e[2:0], cls_q[2].ch[2:0], cls_q[3].ch[2:0]};
          esc_d.used = UsedFour;
        end else if (cls_q[2].is_oct) begin
          esc_d.code = {3'b0, e[2:0], cls_q[2].ch[2:0]};
          esc_d.used = UsedThree;
        end else begin
          esc_d.code = {6'b0, e[2:0]};
        end
      end
      default: begin
        esc_d.code = {1'b0, ChBackslash};
        esc_d.used = UsedOne;
      end
    endcase

    // optional meta prefix, then caret form or plain byte
    meta = cls_q[0].is_m && cls_q[1].is_dash;
    lead = meta ? cls_q[2] : cls_q[0];
    nxt  = meta ? cls_q[3] : cls_q[1];

    txt_d.bad = 1'b0;
    if (lead.is_caret) begin
      txt_d.used = meta ? UsedFour : UsedTwo;
      if (nxt.is_qmark) begin
        txt_d.code = {1'b0, meta, DelCode};
      end else if (nxt.is_upper_ctl || nxt.is_lower_ctl) begin
        txt_d.code = {1'b0, meta, 2'b0, nxt.ch[4:0]};
      end else if (nxt.is_blank) begin
        txt_d.code = {1'b0, meta, ChCaret[6:0]};
      end else begin
        txt_d.code = '0;
        txt_d.used = UsedNone;
        txt_d.bad  = 1'b1;
      end
    end else begin
      txt_d.code = {1'b0, lead.ch | (meta ? MetaBit : 8'h00)};
      txt_d.used = meta ? UsedThree : UsedOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      esc_q    <= esc_d;
      txt_q    <= txt_d;
      is_esc_q <= cls_q[0].is_bslash;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the form, output register
  // --------------------------------------------------------------------------
  ked_res_t res_d, res_q;

  assign res_d = is_esc_q ? esc_q : txt_q;

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {3'b0, res_q.used, res_q.bad, res_q.code};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `KED_ASSERT_NOW(a_bad_is_empty, m_axis_tvalid && res_q.bad,
                  res_q.used == UsedNone && res_q.code == '0,
                  "bad form must give zero code and count")
  `KED_ASSERT_NOW(a_used_range, m_axis_tvalid,
                  res_q.used <= UsedFour && (res_q.bad || res_q.used != UsedNone),
                  "consumed out of range")
  `KED_ASSERT_NEXT(a_s1_handoff, v1_q && rdy2, v2_q, "stage 1 request lost")
  `KED_ASSERT_NOW(a_full_when_stalled, !s_axis_tready, v1_q && v2_q && v3_q,
                  "input stalled with a bubble in the pipe")

endmodule
`default_nettype wire

>>> dv/tb_key_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_escape_decoder
// Stream-level check of the key notation decoder against a local predictor.
// ----------------------------------------------------------------------------
// Four-byte text windows are pushed into the slave side from a queue. Each
// accepted window is decoded by an in-bench predictor and the expected
// result is queued. Every result taken from the master side is checked,
// field by field, against the oldest queued expectation. A short directed
// list goes first, then about 1150 random windows. Most random windows are
// built as escape, caret or meta notations with random content. Both sides
// idle at random, apart from one quiet stretch.
// ----------------------------------------------------------------------------
module tb_key_escape_decoder;
  import ked_pkg::*;

  localparam int unsigned RandomItems = 1150;
  localparam int unsigned CycleLimit  = 100000;
  // No idling on either side while the cycle count is in this window
  localparam int unsigned QuietFrom   = 400;
  localparam int unsigned QuietTo     = 700;
  // Drain pause at the end, covers the three-stage pipeline with margin
  localparam int unsigned DrainCycles = 12;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  // Slave-side request, driven on the falling edge
  logic [31:0] s_tdata = '0;   // char0[7:0], char1[15:8], char2[23:16], char3[31:24]
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready;

  // Master side
  logic [15:0] m_axis_tdata;   // code[8:0], bad_form[9], consumed[12:10]
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;

  logic [31:0] window_q [$];   // windows not yet offered
  ked_res_t    decoded_q [$];  // expected results, oldest first
  logic        win_taken = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;

  key_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic is_octal(input logic [7:0] ch);
    return ch >= ChZero && ch <= ChSeven;
  endfunction

  // 0..15, or 16 when ch is no hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    if (ch >= ChZero && ch <= ChNine) return 5'(ch - ChZero);
    if (ch >= ChLowerA && ch <= ChLowerF) return 5'(ch - ChLowerA + 8'd10);
    if (ch >= ChUpperA && ch <= ChUpperF) return 5'(ch - ChUpperA + 8'd10);
    return 5'd16;
  endfunction

  function automatic ked_res_t decode_notation(input logic [31:0] win);
    logic [7:0]  b [4];
    logic [7:0]  c;
    logic [8:0]  meta;
    logic [4:0]  h1;
    logic [4:0]  h2;
    int unsigned p;
    ked_res_t    r;
    for (int k = 0; k < 4; k++) begin
      b[k] = win[8*k +: 8];
    end
    r = '0;
    if (b[0] == ChBackslash) begin
      r.used = UsedTwo;
      case (b[1])
        ChBackslash: r.code = {1'b0, ChBackslash};
        ChLowerB:    r.code = {1'b0, CodeBs};
        ChLowerF:    r.code = {1'b0, CodeFf};
        ChLowerN:    r.code = {1'b0, CodeLf};
        ChLowerR:    r.code = {1'b0, ChCr};
        ChLowerT:    r.code = {1'b0, ChTab};
        ChLowerX: begin
          h1 = hex_value(b[2]);
          h2 = hex_value(b[3]);
          if (h1[4]) begin
            // no digit: a literal 'x'
            r.code = {1'b0, ChLowerX};
          end else if (h2[4]) begin
            r.code = 9'(h1[3:0]);
            r.used = UsedThree;
          end else begin
            r.code = 9'({h1[3:0], h2[3:0]});
            r.used = UsedFour;
          end
        end
        default: begin
          // octal digits are 0x30..0x37, so the low three bits are the value
          if (is_octal(b[1])) begin
            if (!is_octal(b[2])) begin
              r.code = 9'(b[1][2:0]);
            end else if (!is_octal(b[3])) begin
              r.code = 9'({b[1][2:0], b[2][2:0]});
              r.used = UsedThree;
            end else begin
              r.code = {b[1][2:0], b[2][2:0], b[3][2:0]};
              r.used = UsedFour;
            end
          end else begin
            // unknown escape: lone backslash
            r.code = {1'b0, ChBackslash};
            r.used = UsedOne;
          end
        end
      endcase
    end else begin
      meta = '0;
      p    = 0;
      if (b[0] == ChUpperM && b[1] == ChDash) begin
        meta = {1'b0, MetaBit};
        p    = 2;
      end
      if (b[p] == ChCaret) begin
        c      = b[p+1];
        r.used = (p == 0) ? UsedTwo : UsedFour;
        if (c == ChQmark) begin
          r.code = meta | {2'b0, DelCode};
        end else if (c >= ChAt && c <= ChUnder) begin
          r.code = meta | 9'(c - ChAt);
        end else if (c >= ChLowerA && c <= ChLowerZ) begin
          r.code = meta | 9'(c - ChLowerA + 8'd1);
        end else if (c == ChNul || c == ChSpace || (c >= ChTab && c <= ChCr)) begin
          r.code = meta | {1'b0, ChCaret};
        end else begin
          r.code = '0;
          r.used = UsedNone;
          r.bad  = 1'b1;
        end
      end else begin
        // plain byte, NUL and M-\ included
        r.code = meta | {1'b0, b[p]};
        r.used = (p == 0) ? UsedOne : UsedThree;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [31:0] win4(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3);
    return {b3, b2, b1, b0};
  endfunction

  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 3))
      0:       return ChZero + 8'($urandom_range(0, 9));
      1:       return ChLowerA + 8'($urandom_range(0, 5));
      2:       return ChUpperA + 8'($urandom_range(0, 5));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] oct_char();
    if ($urandom_range(0, 3) != 0) return ChZero + 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  // byte after a caret: every valid class, blanks and junk
  function automatic logic [7:0] caret_follower();
    case ($urandom_range(0, 5))
      0:       return ChQmark;
      1:       return ChAt + 8'($urandom_range(0, 31));
      2:       return ChLowerA + 8'($urandom_range(0, 25));
      3:       return ($urandom_range(0, 2) == 0) ? ChNul : ChSpace;
      4:       return ChTab + 8'($urandom_range(0, 4));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_window();
    logic [31:0] w;
    logic [7:0]  esc;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: ;  // raw noise
      1: begin
        case ($urandom_range(0, 7))
          0:       esc = ChBackslash;
          1:       esc = ChLowerB;
          2:       esc = ChLowerF;
          3:       esc = ChLowerN;
          4:       esc = ChLowerR;
          5:       esc = ChLowerT;
          6:       esc = ChLowerX;
          default: esc = 8'($urandom);
        endcase
        w[15:0] = {esc, ChBackslash};
      end
      2: w = {hex_char(), hex_char(), ChLowerX, ChBackslash};
      3: w = {oct_char(), oct_char(), ChZero + 8'($urandom_range(0, 7)), ChBackslash};
      4: w[15:0] = {caret_follower(), ChCaret};
      5: w = {caret_follower(), ChCaret, ChDash, ChUpperM};
      6: begin
        w[23:0] = {8'($urandom), ChDash, ChUpperM};
        if ($urandom_range(0, 3) == 0) w[23:16] = ChBackslash;
      end
      7: w[7:0] = ChUpperM;     // broken meta prefix, mostly
      8: w[7:0] = ChBackslash;  // escape with any byte after it
      default: w[7:0] = ChCaret;
    endcase
    // short text: NUL past the end
    if ($urandom_range(0, 3) == 0) w &= 32'hFFFF_FFFF >> (8 * $urandom_range(1, 3));
    return w;
  endfunction

  function automatic logic take_break();
    if (cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) return 1'b0;
    return $urandom_range(0, 99) < 11;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new request on the falling edge once the current one is taken
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !take_break();
      if (!s_tvalid || win_taken) begin
        if (window_q.size() != 0 && !take_break()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= window_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input accept, check on output accept
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    ked_res_t got;
    ked_res_t want;
    if (!rst_ni) begin
      win_taken = 1'b0;
    end else begin
      win_taken = s_tvalid && s_axis_tready;
      if (win_taken) decoded_q.push_back(decode_notation(s_tdata));
      if (m_axis_tvalid && m_tready) begin
        got.code = m_axis_tdata[8:0];
        got.bad  = m_axis_tdata[9];
        got.used = m_axis_tdata[12:10];
        if (decoded_q.size() == 0) begin
          $error("result with nothing pending: tdata %h", m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (got.code != want.code) begin
            $error("code: expected %0d, got %0d", want.code, got.code);
            mismatch_cnt++;
          end
          if (got.bad != want.bad) begin
            $error("bad_form: expected %0d, got %0d", want.bad, got.bad);
            mismatch_cnt++;
          end
          if (got.used != want.used) begin
            $error("consumed: expected %0d, got %0d", want.used, got.used);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Directed: every escape, hex and octal lengths, caret classes, meta forms
    window_q.push_back(win4(ChNul, ChNul, ChNul, ChNul));               // NUL text
    window_q.push_back(win4(8'hFF, 8'hFF, 8'hFF, 8'hFF));               // top byte
    window_q.push_back(win4(ChBackslash, ChBackslash, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerB, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerF, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerN, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerR, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerT, ChNul, ChNul));
    window_q.push_back(win4(ChBackslash, ChLowerX, ChUpperF, ChLowerZ)); // one hex
    window_q.push_back(win4(ChBackslash, ChLowerX, ChLowerA, ChLowerF)); // two hex
    window_q.push_back(win4(ChBackslash, ChLowerX, ChLowerZ, ChNul));    // bare x
    window_q.push_back(win4(ChBackslash, ChSeven, ChNine, ChNul));
    window_q.push_back(win4(ChBackslash, ChSeven, ChSeven, ChNine));
    window_q.push_back(win4(ChBackslash, ChSeven, ChSeven, ChSeven));    // 0777
    window_q.push_back(win4(ChBackslash, ChUpperM, ChNul, ChNul));       // unknown
    window_q.push_back(win4(ChCaret, ChQmark, ChNul, ChNul));
    window_q.push_back(win4(ChCaret, ChAt, ChNul, ChNul));
    window_q.push_back(win4(ChCaret, ChUnder, ChNul, ChNul));
    window_q.push_back(win4(ChCaret, ChLowerZ, ChNul, ChNul));
    window_q.push_back(win4(ChCaret, ChNul, ChNul, ChNul));              // caret at end
    window_q.push_back(win4(ChCaret, ChSpace, ChNul, ChNul));
    window_q.push_back(win4(ChCaret, ChDash, ChNul, ChNul));             // bad caret
    window_q.push_back(win4(ChUpperM, ChDash, ChCaret, ChQmark));
    window_q.push_back(win4(ChUpperM, ChDash, ChCaret, ChTab));          // meta kept
    window_q.push_back(win4(ChUpperM, ChDash, ChCaret, ChDash));         // bad after meta
    window_q.push_back(win4(ChUpperM, ChDash, ChBackslash, ChLowerN));   // no escape
    window_q.push_back(win4(ChUpperM, ChDash, ChNul, ChNul));
    repeat (RandomItems) window_q.push_back(random_window());

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // all requests taken, then all results back, then a short drain
    wait (window_q.size() == 0 && !s_tvalid);
    wait (decoded_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ked_pkg.sv
rtl/ked_byte_class.sv
rtl/key_escape_decoder.sv
dv/tb_key_escape_decoder.sv
